>>> src/qbc_pkg.sv
// qbc_pkg: shared types, constants and arithmetic helpers for the quintic blend coefficient unit.
package qbc_pkg;

    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = 13;
    localparam int DIVIDEND_W  = DIV_BITS * DIV_STAGES;
    localparam int RECIP_SHIFT = 48;
    localparam int VMAG_W      = 40;
    localparam int N_TERMS     = 12;
    localparam int TERMS_PER_COEF = 4;
    localparam int PADDR_W     = 3;

    localparam logic [63:0] MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;

    localparam logic [0:0]  REG_FRAME_TIME   = 1'b0;
    localparam logic [31:0] FRAME_TIME_RESET = 32'd2185;

    typedef struct packed {
        logic signed [31:0] displacement;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [31:0]        time_left;
        logic               command_valid;
        logic [2:0]         group_index;
        logic signed [31:0] focus_speed;
    } in_item_t;

    typedef struct packed {
        logic               updated;
        logic signed [63:0] coef_a;
        logic signed [63:0] coef_b;
        logic signed [63:0] coef_c;
        logic signed [63:0] coef_e;
        logic signed [63:0] coef_f;
    } out_item_t;

    typedef enum logic [1:0] {SRC_Q, SRC_X, SRC_V, SRC_F} term_src_t;
    typedef enum logic [1:0] {POW_R, POW_P2, POW_P3, POW_P4} term_pow_t;

    // terms 0..3 feed coef_a, 4..7 coef_b, 8..11 coef_c
    localparam term_src_t TERM_SRC [N_TERMS] = '{
        SRC_Q, SRC_X, SRC_V, SRC_F,
        SRC_Q, SRC_X, SRC_V, SRC_F,
        SRC_Q, SRC_X, SRC_V, SRC_F};
    localparam term_pow_t TERM_POW [N_TERMS] = '{
        POW_P3, POW_P4, POW_P3, POW_P4,
        POW_P2, POW_P4, POW_P3, POW_P3,
        POW_R,  POW_P3, POW_P2, POW_P2};
    localparam logic TERM_HALF [N_TERMS] = '{
        1'b1, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0};
    localparam logic TERM_MINUS [N_TERMS] = '{
        1'b0, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b1};
    localparam logic [63:0] TERM_K [N_TERMS] = '{
        64'd1, 64'd6,  64'd3, 64'd3,
        64'd1, 64'd15, 64'd7, 64'd8,
        64'd1, 64'd10, 64'd4, 64'd6};
    localparam logic [63:0] TERM_LIM [N_TERMS] = '{
        MAG_CAP / 64'd1, MAG_CAP / 64'd6,  MAG_CAP / 64'd3, MAG_CAP / 64'd3,
        MAG_CAP / 64'd1, MAG_CAP / 64'd15, MAG_CAP / 64'd7, MAG_CAP / 64'd8,
        MAG_CAP / 64'd1, MAG_CAP / 64'd10, MAG_CAP / 64'd4, MAG_CAP / 64'd6};

    typedef struct packed {
        logic               blend;
        logic signed [31:0] x;
        logic signed [63:0] e;
        logic [31:0]        xm;
        logic [31:0]        vm;
        logic [31:0]        qm;
        logic [VMAG_W-1:0]  fm;
        logic               xn;
        logic               vn;
        logic               qn;
        logic               fn;
        logic [31:0]        t;
    } op_t;

    typedef struct packed {
        logic [63:0] r;
        logic [63:0] p2;
        logic [63:0] p3;
        logic [63:0] p4;
    } pw_t;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } pp_t;

    // four 32x32 partial products of a 64x64 multiply
    function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        pp_t pp;
        pp.ll = a[31:0]  * b[31:0];
        pp.lh = a[31:0]  * b[63:32];
        pp.hl = a[63:32] * b[31:0];
        pp.hh = a[63:32] * b[63:32];
        return pp;
    endfunction

    function automatic logic [127:0] mul_sum(input pp_t pp);
        return {64'd0, pp.ll} + {32'd0, pp.lh, 32'd0} + {32'd0, pp.hl, 32'd0}
             + {pp.hh, 64'd0};
    endfunction

    // Q.32 power step, saturating
    function automatic logic [63:0] pow_fold(input logic [127:0] s);
        return (s[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : s[95:32];
    endfunction

    function automatic logic [63:0] term_fold(input logic [127:0] s, input logic half,
                                              input logic [63:0] k, input logic [63:0] lim);
        logic [127:0] w;
        w = half ? (s >> 17) : (s >> 16);
        if (w[127:64] != 64'd0 || w[63:0] > lim)
            return MAG_CAP;
        return w[63:0] * k;
    endfunction

endpackage

>>> src/quintic_blend_coefficients_unit.sv
// quintic_blend_coefficients_unit: pipelined quintic blend coefficient datapath with APB config.
// One register per stage, 24 stages from input beat to output beat.
// Throughput: one beat per cycle; the whole pipe advances together and holds when the
//   output beat is stalled, so in_ready follows out_ready while the output stage is full.
// Stages: input register, 13 reciprocal stages (4 restoring steps each), 6 for r^2..r^4,
//   3 for the twelve terms, one for the sums and saturation in the output register.
// Reset: rst_n clears the valid bits and restores frame_time to 2185; data is not reset.
module quintic_blend_coefficients_unit
    import qbc_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 30
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [7:0] TPS = 8'(TICKS_PER_SECOND);

    // stage map
    localparam int STG_PP2  = DIV_STAGES + 1;  // r*r partial products
    localparam int STG_P2   = DIV_STAGES + 2;
    localparam int STG_PP3  = DIV_STAGES + 3;
    localparam int STG_P3   = DIV_STAGES + 4;
    localparam int STG_PP4  = DIV_STAGES + 5;
    localparam int STG_P4   = DIV_STAGES + 6;
    localparam int STG_TPP  = DIV_STAGES + 7;  // term partial products
    localparam int STG_TSUM = DIV_STAGES + 8;  // term full products
    localparam int STG_TVAL = DIV_STAGES + 9;  // signed, capped terms
    localparam int STG_OUT  = DIV_STAGES + 10; // coefficient sums, output register

    // ------------------------------------------------------------------
    // Configuration port: single register, zero wait states.
    // ------------------------------------------------------------------
    logic [31:0] frame_time_reg;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_FRAME_TIME);
    assign prdata  = cfg_hit ? frame_time_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= FRAME_TIME_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            frame_time_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together on adv. A bubble in the
    // output stage lets the pipe move even while out_ready is low.
    // ------------------------------------------------------------------
    logic [STG_OUT:0] vld_reg;
    logic [STG_OUT:0] vld_next;
    logic             adv;

    assign adv       = out_ready || !vld_reg[STG_OUT];
    assign in_ready  = adv;
    assign out_valid = vld_reg[STG_OUT];
    assign vld_next  = {vld_reg[STG_OUT-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: blend decision, sign/magnitude split, V = ticks * focus for group 0, else zero.
    // ------------------------------------------------------------------
    op_t               op_reg [0:STG_OUT-1];
    op_t               op0_next;
    logic [31:0]       fs_mag;
    logic [VMAG_W-1:0] vmag;
    logic              pos_grp;

    always_comb
    begin
        pos_grp = (in_data.group_index == 3'd0);
        fs_mag  = in_data.focus_speed[31] ? (~in_data.focus_speed + 32'd1)
                                          : in_data.focus_speed;
        vmag    = pos_grp ? ({8'd0, fs_mag} * {32'd0, TPS}) : '0;

        op0_next.blend = in_data.command_valid && (in_data.time_left > frame_time_reg);
        op0_next.x     = in_data.displacement;
        op0_next.xn    = in_data.displacement[31];
        op0_next.vn    = in_data.velocity[31];
        op0_next.qn    = in_data.acceleration[31];
        op0_next.fn    = in_data.focus_speed[31];
        op0_next.xm    = op0_next.xn ? (~in_data.displacement + 32'd1) : in_data.displacement;
        op0_next.vm    = op0_next.vn ? (~in_data.velocity + 32'd1) : in_data.velocity;
        op0_next.qm    = op0_next.qn ? (~in_data.acceleration + 32'd1) : in_data.acceleration;
        op0_next.fm    = vmag;
        op0_next.e     = op0_next.fn ? -$signed({8'd0, vmag, 16'd0})
                                     : $signed({8'd0, vmag, 16'd0});
        op0_next.t     = in_data.time_left;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0] <= op0_next;
            for (int i = 1; i < STG_OUT; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..13: r = floor(2^48 / t), restoring, 4 quotient bits a stage.
    // ------------------------------------------------------------------
    logic [31:0]           rem_reg  [1:DIV_STAGES];
    logic [31:0]           rem_next [1:DIV_STAGES];
    logic [DIVIDEND_W-1:0] quo_reg  [1:DIV_STAGES];
    logic [DIVIDEND_W-1:0] quo_next [1:DIV_STAGES];

    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        logic [31:0]           rem_in;
        logic [DIVIDEND_W-1:0] quo_in;

        if (g == 1)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            logic [32:0]           acc;
            logic [31:0]           rem;
            logic [DIVIDEND_W-1:0] quo;
            logic                  qbit;
            rem = rem_in;
            quo = quo_in;
            for (int s = 0; s < DIV_BITS; s++)
            begin
                acc  = {rem, ((DIVIDEND_W - 1 - ((g - 1) * DIV_BITS + s)) == RECIP_SHIFT)
                             ? 1'b1 : 1'b0};
                qbit = 1'b0;
                if (acc >= {1'b0, op_reg[g-1].t})
                begin
                    acc  = acc - {1'b0, op_reg[g-1].t};
                    qbit = 1'b1;
                end
                rem = acc[31:0];
                quo = {quo[DIVIDEND_W-2:0], qbit};
            end
            rem_next[g] = rem;
            quo_next[g] = quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 14..19: r^2, r^3, r^4, each a partial-product stage and a fold stage.
    // ------------------------------------------------------------------
    pw_t pw_reg  [STG_PP2:STG_P4];
    pw_t pw_next [STG_PP2:STG_P4];
    pp_t pp_reg  [STG_PP2:STG_P4];
    pp_t pp_next [STG_PP2:STG_P4];

    always_comb
    begin
        pw_next[STG_PP2]    = '0;
        pw_next[STG_PP2].r  = {{(64 - DIVIDEND_W){1'b0}}, quo_reg[DIV_STAGES]};
        pp_next[STG_PP2]    = mul_parts(pw_next[STG_PP2].r, pw_next[STG_PP2].r);

        pw_next[STG_P2]     = pw_reg[STG_PP2];
        pw_next[STG_P2].p2  = pow_fold(mul_sum(pp_reg[STG_PP2]));
        pp_next[STG_P2]     = pp_reg[STG_PP2];

        pw_next[STG_PP3]    = pw_reg[STG_P2];
        pp_next[STG_PP3]    = mul_parts(pw_reg[STG_P2].p2, pw_reg[STG_P2].r);

        pw_next[STG_P3]     = pw_reg[STG_PP3];
        pw_next[STG_P3].p3  = pow_fold(mul_sum(pp_reg[STG_PP3]));
        pp_next[STG_P3]     = pp_reg[STG_PP3];

        pw_next[STG_PP4]    = pw_reg[STG_P3];
        pp_next[STG_PP4]    = mul_parts(pw_reg[STG_P3].p3, pw_reg[STG_P3].r);

        pw_next[STG_P4]     = pw_reg[STG_PP4];
        pw_next[STG_P4].p4  = pow_fold(mul_sum(pp_reg[STG_PP4]));
        pp_next[STG_P4]     = pp_reg[STG_PP4];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = STG_PP2; i <= STG_P4; i++)
            begin
                pw_reg[i] <= pw_next[i];
                pp_reg[i] <= pp_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 20..22: the twelve terms K * |src| * power, capped and signed.
    // ------------------------------------------------------------------
    pp_t                tpp_reg   [N_TERMS];
    pp_t                tpp_next  [N_TERMS];
    logic [127:0]       tsum_reg  [N_TERMS];
    logic [127:0]       tsum_next [N_TERMS];
    logic signed [63:0] tval_reg  [N_TERMS];
    logic signed [63:0] tval_next [N_TERMS];

    for (genvar i = 0; i < N_TERMS; i++)
    begin : g_term
        logic [63:0] src_mag;
        logic [63:0] pow_val;
        logic        src_neg;
        logic [63:0] mag;

        always_comb
        begin
            case (TERM_SRC[i])
                SRC_Q:   src_mag = {32'd0, op_reg[STG_P4].qm};
                SRC_X:   src_mag = {32'd0, op_reg[STG_P4].xm};
                SRC_V:   src_mag = {32'd0, op_reg[STG_P4].vm};
                SRC_F:   src_mag = {{(64 - VMAG_W){1'b0}}, op_reg[STG_P4].fm};
                default: src_mag = '0;
            endcase
            case (TERM_POW[i])
                POW_R:   pow_val = pw_reg[STG_P4].r;
                POW_P2:  pow_val = pw_reg[STG_P4].p2;
                POW_P3:  pow_val = pw_reg[STG_P4].p3;
                POW_P4:  pow_val = pw_reg[STG_P4].p4;
                default: pow_val = '0;
            endcase
            case (TERM_SRC[i])
                SRC_Q:   src_neg = op_reg[STG_TSUM].qn;
                SRC_X:   src_neg = op_reg[STG_TSUM].xn;
                SRC_V:   src_neg = op_reg[STG_TSUM].vn;
                SRC_F:   src_neg = op_reg[STG_TSUM].fn;
                default: src_neg = 1'b0;
            endcase
            tpp_next[i]  = mul_parts(src_mag, pow_val);
            tsum_next[i] = mul_sum(tpp_reg[i]);
            mag          = term_fold(tsum_reg[i], TERM_HALF[i], TERM_K[i], TERM_LIM[i]);
            tval_next[i] = (src_neg != TERM_MINUS[i]) ? -$signed(mag) : $signed(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N_TERMS; i++)
            begin
                tpp_reg[i]  <= tpp_next[i];
                tsum_reg[i] <= tsum_next[i];
                tval_reg[i] <= tval_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 23: exact four-term sums, saturation, output register.
    // ------------------------------------------------------------------
    out_item_t          res_reg;
    out_item_t          res_next;
    logic signed [65:0] csum [3];
    logic        [63:0] csat [3];
    op_t                op_last;

    assign op_last = op_reg[STG_TVAL];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            csum[c] = '0;
            for (int j = 0; j < TERMS_PER_COEF; j++)
            begin
                csum[c] = csum[c] + {{2{tval_reg[c*TERMS_PER_COEF+j][63]}},
                                     tval_reg[c*TERMS_PER_COEF+j]};
            end
            if (csum[c][65:63] == 3'b000 || csum[c][65:63] == 3'b111)
                csat[c] = csum[c][63:0];
            else
                csat[c] = csum[c][65] ? NEG_CAP : MAG_CAP;
        end

        res_next.updated = op_last.blend;
        res_next.coef_a  = op_last.blend ? $signed(csat[0]) : '0;
        res_next.coef_b  = op_last.blend ? $signed(csat[1]) : '0;
        res_next.coef_c  = op_last.blend ? $signed(csat[2]) : '0;
        res_next.coef_e  = op_last.blend ? op_last.e : '0;
        res_next.coef_f  = op_last.blend ? $signed({{16{op_last.x[31]}}, op_last.x, 16'd0})
                                         : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = res_reg;

endmodule

>>> src/qbc_checker.sv
// qbc_checker: port-level assertions for the quintic blend coefficient unit, with its bind.
module qbc_checker
    import qbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input in_item_t           in_data,
    input logic               out_valid,
    input logic               out_ready,
    input out_item_t          out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // a beat that was not recomputed carries all-zero coefficients
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.updated |->
            out_data.coef_a == 64'd0 && out_data.coef_b == 64'd0 &&
            out_data.coef_c == 64'd0 && out_data.coef_e == 64'd0 &&
            out_data.coef_f == 64'd0)
        else $error("non-updated beat has nonzero coefficients");

    // e and f come from Q16.16 values, so their low 16 bits are clear
    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.coef_e[15:0] == 16'd0 && out_data.coef_f[15:0] == 16'd0)
        else $error("coef_e or coef_f low fraction bits set");

    // a written frame_time reads back
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_FRAME_TIME |=>
            paddr[PADDR_W-1:2] != REG_FRAME_TIME || prdata == $past(pwdata))
        else $error("frame_time readback mismatch");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

endmodule

bind quintic_blend_coefficients_unit qbc_checker u_qbc_checker (.*);
